// ----- sv/efcd_pkg.sv -----
package efcd_pkg;

  // Ring geometry and arc length limits
  localparam int InnerPts   = 16;
  localparam int OuterPts   = 20;
  localparam int RingPts    = InnerPts + OuterPts;
  localparam int RingMargin = 4;
  localparam int InnerLo    = 3;
  localparam int InnerHi    = 6;
  localparam int OuterLo    = 4;
  localparam int OuterHi    = 8;
  localparam int Lanes      = OuterHi - OuterLo + 1;

  typedef logic [31:0] stamp_t;
  typedef logic [5:0]  ring_idx_t;

  // One ring sample coming back from the surface memory
  typedef struct packed {
    logic      valid;
    ring_idx_t idx;
    stamp_t    data;
  } ring_load_t;

  typedef struct packed {
    logic start;
    logic outer;
  } arc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic pass;
  } arc_stat_t;

  // Ring offsets: inner ring first (radius 3), then outer ring (radius 4)
  localparam logic signed [3:0] RingDx [RingPts] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1,
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1
  };

  localparam logic signed [3:0] RingDy [RingPts] = '{
    4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
    4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4
  };

endpackage

// ----- sv/event_fast_corner_detector.sv -----
// Flow: the timestamp is stored after the StRow and StCtr address states, then the ring
// samples are read one after another and the arc sweeps run, inner ring first and outer
// only if the inner passes; a corner waits in the output register under an output stall.
// One event at a time, set by the arc sweep unit and the single surface memory read port;
// events outside the sensor are dropped and those near the border are only stored.
// Reset: rst_ni clears the surface memory one entry a cycle (4*SENSOR_WIDTH*SENSOR_HEIGHT).
module event_fast_corner_detector #(
  parameter int SENSOR_WIDTH  = 304,
  parameter int SENSOR_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // pix_x[8:0], pix_y[16:9], stamp[48:17], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // sensor_side[0], polarity[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // corner_x[8:0], corner_y[16:9], corner_stamp[48:17]
  output logic [1:0]  m_axis_tuser_o   // corner_side[0], corner_polarity[1]
);

  localparam int Depth = 4 * SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int RowW  = $clog2(4 * SENSOR_HEIGHT);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRow   = 4'd2;
  localparam logic [3:0] StCtr   = 4'd3;
  localparam logic [3:0] StWr    = 4'd4;
  localparam logic [3:0] StRd    = 4'd5;
  localparam logic [3:0] StDrain = 4'd6;
  localparam logic [3:0] StInner = 4'd7;
  localparam logic [3:0] StOuter = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [8:0]          x_q;
  logic [7:0]          y_q;
  logic                side_q, pol_q;
  efcd_pkg::stamp_t    stamp_q;
  logic [RowW-1:0]     row_q;
  logic [AW-1:0]       center_q;
  efcd_pkg::ring_idx_t k_q, k_d, rd_idx_q;
  logic                rd_v_q;
  logic                out_v_q;
  logic [55:0]         out_data_q;
  logic [1:0]          out_user_q;

  logic                in_xfer, in_range, border;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  efcd_pkg::stamp_t    wdata, rdata;
  efcd_pkg::ring_load_t ld;
  efcd_pkg::arc_cmd_t  cmd;
  efcd_pkg::arc_stat_t stat;
  int                  ring_off;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = (int'(s_axis_tdata_i[8:0]) < SENSOR_WIDTH) &&
                    (int'(s_axis_tdata_i[16:9]) < SENSOR_HEIGHT);
  assign border   = (int'(x_q) < efcd_pkg::RingMargin) ||
                    (int'(y_q) < efcd_pkg::RingMargin) ||
                    (int'(x_q) + efcd_pkg::RingMargin >= SENSOR_WIDTH) ||
                    (int'(y_q) + efcd_pkg::RingMargin >= SENSOR_HEIGHT);

  // Memory port steering: clear sweep or event store, ring reads
  always_comb begin
    ring_off = int'(efcd_pkg::RingDy[k_q]) * SENSOR_WIDTH + int'(efcd_pkg::RingDx[k_q]);
    raddr    = center_q + AW'(ring_off);
    we       = (state_q == StClear) || (state_q == StWr);
    waddr    = (state_q == StClear) ? clr_q : center_q;
    wdata    = (state_q == StClear) ? '0 : stamp_q;
  end

  efcd_ram #(
    .WIDTH (32),
    .DEPTH (Depth)
  ) u_surf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ld = '{valid: rd_v_q, idx: rd_idx_q, data: rdata};

  efcd_arc u_arc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    cmd     = '{start: 1'b0, outer: 1'b0};
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_xfer && in_range) begin
          state_d = StRow;
        end
      end
      StRow: state_d = StCtr;
      StCtr: state_d = StWr;
      StWr: begin
        k_d     = '0;
        state_d = border ? StIdle : StRd;
      end
      StRd: begin
        if (k_q == 6'(efcd_pkg::RingPts - 1)) begin
          state_d = StDrain;
        end else begin
          k_d = k_q + 6'd1;
        end
      end
      StDrain: begin
        cmd     = '{start: 1'b1, outer: 1'b0};
        state_d = StInner;
      end
      StInner: begin
        if (stat.done) begin
          if (stat.pass) begin
            cmd     = '{start: 1'b1, outer: 1'b1};
            state_d = StOuter;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOuter: begin
        if (stat.done) begin
          state_d = stat.pass ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (!out_v_q || m_axis_tready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      rd_v_q  <= (state_q == StRd);
      if (state_q == StEmit && (!out_v_q || m_axis_tready_i)) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Event fields, address math and result payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= k_q;
    if (in_xfer) begin
      x_q     <= s_axis_tdata_i[8:0];
      y_q     <= s_axis_tdata_i[16:9];
      stamp_q <= s_axis_tdata_i[48:17];
      side_q  <= s_axis_tuser_i[0];
      pol_q   <= s_axis_tuser_i[1];
    end
    if (state_q == StRow) begin
      row_q <= RowW'(int'({side_q, pol_q}) * SENSOR_HEIGHT) + RowW'(y_q);
    end
    if (state_q == StCtr) begin
      center_q <= AW'(int'(row_q) * SENSOR_WIDTH) + AW'(x_q);
    end
    if (state_q == StEmit && (!out_v_q || m_axis_tready_i)) begin
      out_data_q <= {7'b0, stamp_q, y_q, x_q};
      out_user_q <= {pol_q, side_q};
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == StClear || state_q == StWr))
    else $error("surface write outside clear or store");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !stat.busy)
    else $error("arc start while sweep busy");
  a_load_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == StRd || state_q == StDrain))
    else $error("ring sample outside read window");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (state_q == StInner || state_q == StOuter))
    else $error("arc result with no waiting sequencer");
`endif

endmodule

// ----- sv/efcd_ram.sv -----
module efcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/efcd_arc.sv -----
// Arc test: for each start position until an arc passes, sweeps the ring once, one pixel a cycle.
// Lanes track every allowed arc length in parallel.
module efcd_arc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  efcd_pkg::ring_load_t ld_i,
  input  efcd_pkg::arc_cmd_t  cmd_i,
  output efcd_pkg::arc_stat_t stat_o
);

  efcd_pkg::stamp_t inner_q [efcd_pkg::InnerPts];
  efcd_pkg::stamp_t outer_q [efcd_pkg::OuterPts];

  logic             busy_q, sel_q, done_q, pass_q;
  logic [4:0]       i_q, j_q;
  efcd_pkg::stamp_t first_q, prev_q, pmin_q, pmin_n, v;
  efcd_pkg::stamp_t lmin_q [efcd_pkg::Lanes];
  efcd_pkg::stamp_t lmin_d [efcd_pkg::Lanes];
  logic [efcd_pkg::Lanes-1:0] ok_q, ok_d, lane_en;
  logic [4:0]       n, pos;
  logic [5:0]       sum;
  logic [3:0]       lo, hi;
  logic             pass_now;

  // Ring sample at offset j from start i
  always_comb begin
    n   = sel_q ? 5'(efcd_pkg::OuterPts) : 5'(efcd_pkg::InnerPts);
    lo  = sel_q ? 4'(efcd_pkg::OuterLo) : 4'(efcd_pkg::InnerLo);
    hi  = sel_q ? 4'(efcd_pkg::OuterHi) : 4'(efcd_pkg::InnerHi);
    sum = {1'b0, i_q} + {1'b0, j_q};
    pos = (sum >= {1'b0, n}) ? 5'(sum - {1'b0, n}) : sum[4:0];
    v   = sel_q ? outer_q[pos] : inner_q[pos[3:0]];
  end

  // Prefix minimum and per-length checks
  always_comb begin
    logic [3:0] len;
    logic       ok_cur;
    pmin_n = (j_q == 5'd0) ? v : ((v < pmin_q) ? v : pmin_q);
    for (int l = 0; l < efcd_pkg::Lanes; l++) begin
      len        = lo + 4'(l);
      lane_en[l] = (len <= hi);
      ok_cur     = (j_q == 5'd0) ? 1'b1 : ok_q[l];
      if ({1'b0, j_q} < {2'b0, len}) begin
        lmin_d[l] = pmin_n;
        ok_d[l]   = ok_cur;
      end else begin
        lmin_d[l] = lmin_q[l];
        ok_d[l]   = ok_cur && (v < lmin_q[l]) &&
                    (({1'b0, j_q} != {2'b0, len}) || (prev_q >= v));
      end
    end
    // On the last step v is the pixel before the arc start
    pass_now = (first_q >= v) && |(ok_d & lane_en);
  end

  // Sample loading
  always_ff @(posedge clk_i) begin
    if (ld_i.valid) begin
      if (ld_i.idx < 6'(efcd_pkg::InnerPts)) begin
        inner_q[ld_i.idx[3:0]] <= ld_i.data;
      end else begin
        outer_q[5'(ld_i.idx - 6'(efcd_pkg::InnerPts))] <= ld_i.data;
      end
    end
  end

  // Sweep datapath
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prev_q <= v;
      pmin_q <= pmin_n;
      ok_q   <= ok_d;
      lmin_q <= lmin_d;
      if (j_q == 5'd0) begin
        first_q <= v;
      end
    end
  end

  // Sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= 1'b0;
      done_q <= 1'b0;
      pass_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        sel_q  <= cmd_i.outer;
        i_q    <= '0;
        j_q    <= '0;
      end else if (busy_q) begin
        if (j_q == n - 5'd1) begin
          j_q <= '0;
          if (pass_now) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            pass_q <= 1'b1;
          end else if (i_q == n - 5'd1) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            pass_q <= 1'b0;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end else begin
          j_q <= j_q + 5'd1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q, pass: pass_q};

endmodule
